// File: sv/pedt_pkg.sv
// Shared types and codes for the periodic event divider table.
package pedt_pkg;

    localparam int ID_W    = 8;
    localparam int CLASS_W = 2;
    localparam int LIMIT_W = 16;

    localparam logic [1:0] CMD_TICK   = 2'd0;
    localparam logic [1:0] CMD_INSERT = 2'd1;
    localparam logic [1:0] CMD_DELETE = 2'd2;

    localparam logic [1:0] KIND_FIRE   = 2'd0;
    localparam logic [1:0] KIND_DONE   = 2'd1;
    localparam logic [1:0] KIND_INSERT = 2'd2;
    localparam logic [1:0] KIND_DELETE = 2'd3;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    typedef struct packed {
        logic               valid;
        logic [ID_W-1:0]    id;
        logic [CLASS_W-1:0] cls;
        logic [LIMIT_W-1:0] limit;
        logic [LIMIT_W-1:0] count;
    } entry_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_ROTATE,
        CELL_SHIFT,
        CELL_LOAD
    } cell_op_t;

endpackage

// File: sv/pedt_cell.sv
// One table cell: holds an event entry and takes its neighbor's entry on rotate or shift.
module pedt_cell (
    input  logic                               clk,
    input  logic                               rst_n,
    input  pedt_pkg::cell_op_t                 op,
    input  pedt_pkg::entry_t                   nxt,
    input  pedt_pkg::entry_t                   load,
    input  logic [pedt_pkg::ID_W-1:0]          key,
    output pedt_pkg::entry_t                   ent,
    output logic                               match
);

    pedt_pkg::entry_t entry_reg;
    pedt_pkg::entry_t entry_next;

    always_comb
    begin
        case (op)
            pedt_pkg::CELL_ROTATE: entry_next = nxt;
            pedt_pkg::CELL_SHIFT:  entry_next = nxt;
            pedt_pkg::CELL_LOAD:   entry_next = load;
            default:               entry_next = entry_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
        end
        else
        begin
            entry_reg <= entry_next;
        end
    end

    assign ent   = entry_reg;
    assign match = entry_reg.valid && (entry_reg.id == key);

endmodule

// File: sv/periodic_event_divider_table_core.sv
// Periodic event divider table: a ring of entry cells kept in firing order.
//
//  channel | signals                                   | dir
//  --------+-------------------------------------------+-----
//  req     | req_valid, req_ready, cmd, event_id,      | in
//          | interval_class, divisor                   |
//  res     | res_valid, res_ready, kind, fired_id,     | out
//          | status, last                              |
//
// Insert and delete each give one result.
// A tick rotates the ring once through all NUM_SLOTS cells, one cell per
// cycle at the head while the output register is free, then gives the done result.
// Rotation pauses while a result waits in the output register and res_ready is low.
// Reset empties the table; no clearing pass.
module periodic_event_divider_table_core #(
    parameter int NUM_SLOTS = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    output logic                              req_ready,
    input  logic [1:0]                        cmd,
    input  logic [pedt_pkg::ID_W-1:0]         event_id,
    input  logic [pedt_pkg::CLASS_W-1:0]      interval_class,
    input  logic [pedt_pkg::LIMIT_W-1:0]      divisor,
    output logic                              res_valid,
    input  logic                              res_ready,
    output logic [1:0]                        kind,
    output logic [pedt_pkg::ID_W-1:0]         fired_id,
    output logic                              status,
    output logic                              last
);

    localparam int CW = $clog2(NUM_SLOTS + 1);
    localparam logic [CW-1:0] LAST_STEP = CW'(NUM_SLOTS);

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_TICK
    } state_t;

    state_t                          state_reg;
    logic [CW-1:0]                   step_reg;
    logic [pedt_pkg::CLASS_W-1:0]    tick_cls_reg;
    logic                            res_valid_reg;
    logic [1:0]                      kind_reg;
    logic [pedt_pkg::ID_W-1:0]       fired_id_reg;
    logic                            status_reg;
    logic                            last_reg;

    pedt_pkg::entry_t                ent [NUM_SLOTS];
    pedt_pkg::entry_t                nbr [NUM_SLOTS];
    pedt_pkg::cell_op_t              op  [NUM_SLOTS];
    pedt_pkg::entry_t                load_ent;
    pedt_pkg::entry_t                head_upd;
    logic [NUM_SLOTS-1:0]            match;
    logic [NUM_SLOTS-1:0]            kill;
    logic [NUM_SLOTS-1:0]            first_free;

    logic                            accept;
    logic                            out_free;
    logic                            step;
    logic                            finish;
    logic                            any_match;
    logic                            ins_ok;
    logic                            del_ok;
    logic                            hit;
    logic                            fire;
    logic                            res_load;
    logic [pedt_pkg::LIMIT_W:0]      cnt_inc;

    assign out_free  = !res_valid_reg || res_ready;
    assign req_ready = (state_reg == ST_IDLE) && out_free;
    assign accept    = req_valid && req_ready;
    assign step      = (state_reg == ST_TICK) && out_free && (step_reg != LAST_STEP);
    assign finish    = (state_reg == ST_TICK) && out_free && (step_reg == LAST_STEP);

    assign any_match = |match;
    assign ins_ok    = accept && (cmd == pedt_pkg::CMD_INSERT) && !any_match
                       && !ent[NUM_SLOTS-1].valid;
    assign del_ok    = accept && (cmd == pedt_pkg::CMD_DELETE) && any_match;

    assign res_load  = (accept && ((cmd == pedt_pkg::CMD_INSERT)
                                   || (cmd == pedt_pkg::CMD_DELETE)))
                       || (step && fire) || finish;

    always_comb
    begin
        load_ent       = '0;
        load_ent.valid = 1'b1;
        load_ent.id    = event_id;
        load_ent.cls   = interval_class;
        load_ent.limit = divisor;
    end

    // head cell update during a tick
    assign hit     = ent[0].valid && (ent[0].cls == tick_cls_reg);
    assign cnt_inc = {1'b0, ent[0].count} + 1'b1;
    assign fire    = hit && (cnt_inc >= {1'b0, ent[0].limit});

    always_comb
    begin
        head_upd = ent[0];
        if (fire)
        begin
            head_upd.count = '0;
        end
        else if (hit)
        begin
            head_upd.count = cnt_inc[pedt_pkg::LIMIT_W-1:0];
        end
    end

    // delete compacts every cell from the matching one onward
    always_comb
    begin
        kill[0] = match[0];
        for (int i = 1; i < NUM_SLOTS; i++)
        begin
            kill[i] = kill[i-1] | match[i];
        end
    end

    genvar g;
    generate
        for (g = 0; g < NUM_SLOTS; g++)
        begin : g_cell
            if (g == 0)
            begin : g_ff0
                assign first_free[g] = !ent[g].valid;
            end
            else
            begin : g_ffn
                assign first_free[g] = !ent[g].valid && ent[g-1].valid;
            end

            if (g < NUM_SLOTS - 1)
            begin : g_nbr
                assign nbr[g] = ent[g+1];
            end
            else
            begin : g_tail
                assign nbr[g] = step ? head_upd : pedt_pkg::entry_t'('0);
            end

            always_comb
            begin
                if (step)
                begin
                    op[g] = pedt_pkg::CELL_ROTATE;
                end
                else if (del_ok && kill[g])
                begin
                    op[g] = pedt_pkg::CELL_SHIFT;
                end
                else if (ins_ok && first_free[g])
                begin
                    op[g] = pedt_pkg::CELL_LOAD;
                end
                else
                begin
                    op[g] = pedt_pkg::CELL_HOLD;
                end
            end

            pedt_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .op    (op[g]),
                .nxt   (nbr[g]),
                .load  (load_ent),
                .key   (event_id),
                .ent   (ent[g]),
                .match (match[g])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            tick_cls_reg  <= '0;
            res_valid_reg <= 1'b0;
            kind_reg      <= pedt_pkg::KIND_FIRE;
            fired_id_reg  <= '0;
            status_reg    <= pedt_pkg::STATUS_OK;
            last_reg      <= 1'b0;
        end
        else
        begin
            if (res_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_valid_reg && res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        case (cmd)
                            pedt_pkg::CMD_TICK:
                            begin
                                state_reg    <= ST_TICK;
                                step_reg     <= '0;
                                tick_cls_reg <= interval_class;
                            end
                            pedt_pkg::CMD_INSERT:
                            begin
                                kind_reg      <= pedt_pkg::KIND_INSERT;
                                fired_id_reg  <= '0;
                                status_reg    <= ins_ok ? pedt_pkg::STATUS_OK
                                                        : pedt_pkg::STATUS_FAIL;
                                last_reg      <= 1'b1;
                            end
                            pedt_pkg::CMD_DELETE:
                            begin
                                kind_reg      <= pedt_pkg::KIND_DELETE;
                                fired_id_reg  <= '0;
                                status_reg    <= del_ok ? pedt_pkg::STATUS_OK
                                                        : pedt_pkg::STATUS_FAIL;
                                last_reg      <= 1'b1;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                ST_TICK:
                begin
                    if (step)
                    begin
                        step_reg <= step_reg + 1'b1;
                        if (fire)
                        begin
                            kind_reg      <= pedt_pkg::KIND_FIRE;
                            fired_id_reg  <= ent[0].id;
                            status_reg    <= pedt_pkg::STATUS_OK;
                            last_reg      <= 1'b0;
                        end
                    end
                    else if (finish)
                    begin
                        state_reg     <= ST_IDLE;
                        kind_reg      <= pedt_pkg::KIND_DONE;
                        fired_id_reg  <= '0;
                        status_reg    <= pedt_pkg::STATUS_OK;
                        last_reg      <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign res_valid = res_valid_reg;
    assign kind      = kind_reg;
    assign fired_id  = fired_id_reg;
    assign status    = status_reg;
    assign last      = last_reg;

endmodule
